FILE: rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants for the three-wire serial master
// Tick item and result layouts, operation and phase codes, size defaults.
// ----------------------------------------------------------------------------
package tws_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_BURST_BYTES_DEF = 31;
  localparam int DIVIDER_WIDTH_DEF   = 10;

  // Fixed field widths
  localparam int HALF_W  = 10;
  localparam int COUNT_W = 5;

  // Operation codes carried on each tick
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_SUPPLY = 2'd2;

  // Link phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CMD   = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         command;
    logic [7:0]         write_byte;
    logic [COUNT_W-1:0] byte_count;
    logic               sda_in;
  } tws_item_t;

  typedef struct packed {
    logic       rst_level;
    logic       sck_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_request;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
  } tws_result_t;

endpackage

FILE: rtl/tws_if.sv
// ----------------------------------------------------------------------------
// tws_if: valid/ready channels of the three-wire serial master
// One interface for tick transactions, one for result transactions.
// ----------------------------------------------------------------------------
interface tws_item_if import tws_pkg::*; ();
  logic      valid;
  logic      ready;
  tws_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tws_result_if import tws_pkg::*; ();
  logic        valid;
  logic        ready;
  tws_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/three_wire_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_serial_master: master for a three-wire real-time-clock link
//
//   channel   dir   payload        handshake
//   tick      in    tws_item_t     valid/ready
//   result    out   tws_result_t   valid/ready
//   cfg       in    half period    cfg_write strobe
//
// One tick transaction is taken per cycle while the result side is not stalled;
// its result passes through the input register, then the result register.
// The single-tick update of the link state sets that rate.
// Reset is synchronous and returns the lines to idle with a half period of 1.
// A stalled result holds the result register and then the input register.
// ----------------------------------------------------------------------------
module three_wire_serial_master import tws_pkg::*; #(
  parameter int MAX_BURST_BYTES = MAX_BURST_BYTES_DEF,
  parameter int DIVIDER_WIDTH   = DIVIDER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  tws_item_if.sink          tick,
  tws_result_if.source      result,
  input  logic              cfg_write,
  input  logic [HALF_W-1:0] cfg_data
);

  logic [HALF_W-1:0] half_period;
  logic              item_valid;
  tws_item_t         item;
  logic              out_valid;
  tws_result_t       out_data;
  tws_result_t       step_result;
  logic              advance;
  logic              take;

  // Pipeline moves when the result register is free or being drained
  assign advance    = !out_valid || result.ready;
  assign tick.ready = !item_valid || advance;
  assign take       = tick.valid && tick.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_W'(1);
    end else if (cfg_write) begin
      half_period <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= tick.data;
    end
  end

  tws_engine #(
    .MAX_BURST_BYTES (MAX_BURST_BYTES),
    .DIVIDER_WIDTH   (DIVIDER_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (item_valid && advance),
    .item        (item),
    .half_period (half_period),
    .result      (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      out_data <= step_result;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  // Read bytes only arrive while the data line is released
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.read_valid |-> !result.data.sda_drive)
    else $error("read byte while data line driven");

  // End of transaction leaves every line idle
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.done_res |->
      !result.data.busy_res && !result.data.sck_level && !result.data.rst_level)
    else $error("done with lines still active");

  // A byte request stalls the clock low with data held at zero
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.byte_request |->
      !result.data.sck_level && !result.data.sda_level)
    else $error("clock or data active while waiting for a byte");

  // Last flag only accompanies a completed byte
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.read_last |-> result.data.read_valid)
    else $error("read_last without read_valid");
`endif

endmodule

FILE: rtl/tws_engine.sv
// ----------------------------------------------------------------------------
// tws_engine: serial link state and one-tick update
// Holds the transfer state and computes the line levels for one tick.
// ----------------------------------------------------------------------------
module tws_engine import tws_pkg::*; #(
  parameter int MAX_BURST_BYTES = MAX_BURST_BYTES_DEF,
  parameter int DIVIDER_WIDTH   = DIVIDER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  tws_item_t          item,
  input  logic [HALF_W-1:0]  half_period,
  output tws_result_t        result
);

  localparam int DW = DIVIDER_WIDTH;
  localparam int LW = (DW > HALF_W) ? DW : HALF_W;

  logic [1:0]         phase,         phase_next;
  logic [2:0]         bit_index,     bit_index_next;
  logic [COUNT_W-1:0] bytes_left,    bytes_left_next;
  logic [7:0]         shift_reg,     shift_reg_next;
  logic [DW-1:0]      divider_count, divider_count_next;
  logic               clock_high,    clock_high_next;
  logic [7:0]         pending_byte,  pending_byte_next;
  logic               pending_valid, pending_valid_next;
  logic               read_mode,     read_mode_next;
  logic               stalled,       stalled_next;

  logic [LW-1:0]      half_wide;
  logic [DW-1:0]      half_masked;
  logic [DW-1:0]      half_limit;
  logic [DW-1:0]      count_inc;
  logic [COUNT_W-1:0] count_sat;
  logic [7:0]         rbyte;
  logic               rvalid;
  logic               rlast;
  logic               done;
  logic               busy;
  logic               drive;

  // Half period limit, a zero setting counts as one tick
  assign half_wide   = LW'(half_period);
  assign half_masked = half_wide[DW-1:0];
  assign half_limit  = (half_masked == '0) ? DW'(1) : half_masked;

  // Saturate the requested burst length
  assign count_sat = (32'(item.byte_count) > 32'(MAX_BURST_BYTES)) ?
                     COUNT_W'(MAX_BURST_BYTES) : item.byte_count;

  // One tick of the link
  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    bytes_left_next    = bytes_left;
    shift_reg_next     = shift_reg;
    divider_count_next = divider_count;
    clock_high_next    = clock_high;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    read_mode_next     = read_mode;
    stalled_next       = stalled;
    rbyte              = 8'd0;
    rvalid             = 1'b0;
    rlast              = 1'b0;
    done               = 1'b0;
    count_inc          = divider_count + DW'(1);

    if (phase == PH_IDLE) begin
      // Launch a transaction with the command byte on the line
      if (item.op == OP_START) begin
        phase_next         = PH_CMD;
        shift_reg_next     = item.command;
        read_mode_next     = item.command[0];
        bytes_left_next    = count_sat;
        bit_index_next     = 3'd0;
        divider_count_next = '0;
        clock_high_next    = 1'b0;
        stalled_next       = 1'b0;
        pending_byte_next  = item.write_byte;
        pending_valid_next = !item.command[0] && (count_sat != '0);
      end
    end else if (stalled) begin
      // Hold the clock low until the next write byte arrives
      if (item.op == OP_SUPPLY) begin
        shift_reg_next     = item.write_byte;
        stalled_next       = 1'b0;
        divider_count_next = '0;
      end
    end else begin
      if (item.op == OP_SUPPLY) begin
        pending_byte_next  = item.write_byte;
        pending_valid_next = 1'b1;
      end
      if (count_inc >= half_limit) begin
        divider_count_next = '0;
        if (!clock_high) begin
          if (phase != PH_CMD && bit_index == 3'd0 && bytes_left == '0) begin
            // Drop all lines at the end of the trailing low half
            phase_next         = PH_IDLE;
            bit_index_next     = 3'd0;
            bytes_left_next    = '0;
            shift_reg_next     = 8'd0;
            clock_high_next    = 1'b0;
            pending_byte_next  = 8'd0;
            pending_valid_next = 1'b0;
            read_mode_next     = 1'b0;
            stalled_next       = 1'b0;
            done               = 1'b1;
          end else begin
            // Rising clock, sample the pin on reads
            if (phase == PH_READ) begin
              shift_reg_next = {item.sda_in, shift_reg[7:1]};
            end
            clock_high_next = 1'b1;
          end
        end else begin
          // Falling clock, advance to the next bit
          clock_high_next = 1'b0;
          if (phase != PH_READ) begin
            shift_reg_next = {1'b0, shift_reg[7:1]};
          end
          bit_index_next = bit_index + 3'd1;
          if (bit_index_next == 3'd0) begin
            if (phase == PH_CMD) begin
              phase_next     = read_mode ? PH_READ : PH_WRITE;
              shift_reg_next = 8'd0;
              if (!read_mode && bytes_left != '0) begin
                if (pending_valid_next) begin
                  shift_reg_next     = pending_byte_next;
                  pending_valid_next = 1'b0;
                end else begin
                  stalled_next       = 1'b1;
                  divider_count_next = '0;
                end
              end
            end else if (phase == PH_READ) begin
              rbyte  = shift_reg;
              rvalid = 1'b1;
              if (bytes_left != '0) begin
                bytes_left_next = bytes_left - COUNT_W'(1);
              end
              rlast          = (bytes_left_next == '0);
              shift_reg_next = 8'd0;
            end else begin
              if (bytes_left != '0) begin
                bytes_left_next = bytes_left - COUNT_W'(1);
              end
              if (bytes_left_next != '0) begin
                if (pending_valid_next) begin
                  shift_reg_next     = pending_byte_next;
                  pending_valid_next = 1'b0;
                end else begin
                  stalled_next       = 1'b1;
                  divider_count_next = '0;
                end
              end
            end
          end
        end
      end else begin
        divider_count_next = count_inc;
      end
    end
  end

  // Line levels after the tick
  assign busy  = (phase_next != PH_IDLE);
  assign drive = (phase_next != PH_READ);

  always_comb begin
    result.rst_level    = busy;
    result.sck_level    = busy && clock_high_next;
    result.sda_level    = busy && drive && !stalled_next && shift_reg_next[0];
    result.sda_drive    = drive;
    result.busy_res     = busy;
    result.byte_request = busy && stalled_next;
    result.read_byte    = rvalid ? rbyte : 8'd0;
    result.read_valid   = rvalid;
    result.read_last    = rvalid && rlast;
    result.done_res     = done;
  end

  // Commit the state on each processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= 3'd0;
      bytes_left    <= '0;
      shift_reg     <= 8'd0;
      divider_count <= '0;
      clock_high    <= 1'b0;
      pending_byte  <= 8'd0;
      pending_valid <= 1'b0;
      read_mode     <= 1'b0;
      stalled       <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      bytes_left    <= bytes_left_next;
      shift_reg     <= shift_reg_next;
      divider_count <= divider_count_next;
      clock_high    <= clock_high_next;
      pending_byte  <= pending_byte_next;
      pending_valid <= pending_valid_next;
      read_mode     <= read_mode_next;
      stalled       <= stalled_next;
    end
  end

endmodule
